>>> rtl/nas_pkg.sv
// Package with the shared types and constants of the next alarm selector.
`default_nettype none

package nas_pkg;

   // Action codes of a request.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Fixed values of the alarm format.
   localparam logic [15:0] DAY_MINUTES = 16'd1440;
   localparam logic [7:0]  UNSET_BYTE  = 8'hFF;
   localparam logic [7:0]  MODE_ACTIVE = 8'h01;
   localparam logic [15:0] DIST_START  = 16'hFFFF;
   localparam logic [13:0] UNTIL_MAX   = 14'h3FFF;
   localparam logic [13:0] HOUR_MINUTES = 14'd60;

   // One request transaction.
   typedef struct packed {
      logic        action;
      logic [4:0]  entry_index;
      logic [7:0]  entry_mode;
      logic [7:0]  entry_hour_bcd;
      logic [7:0]  entry_minute_bcd;
      logic [10:0] now_minutes;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic        found;
      logic [7:0]  alarm_hour_bcd;
      logic [7:0]  alarm_minute_bcd;
      logic [13:0] minutes_until;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   // Two BCD digits to binary, digits taken as they are.
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'b0000, b[7:4]} * 8'd10;
      return hi + {4'b0000, b[3:0]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/next_alarm_selector_top.sv
// Next alarm selector: alarm table memory, scan pipeline and response register.
//
// Usage: a request transaction either writes one alarm entry (action 0) or
// asks for the next alarm after now_minutes (action 1). Every request gives
// exactly one response transaction; a write answers "not found".
// The table lives in a synchronous single-port-read memory of ENTRIES words.
// A query reads every entry once, one per cycle, through a two-stage compare
// pipeline; a write goes straight from idle to the hold state that loads its
// response. One request is worked on at a time, so a new request is taken
// only once the response of the last one has been loaded.
// req_ready is high when the block is free, also while an earlier response
// still waits in the response register.
// If the receiver stalls, the response register holds its transaction and a
// finished new result waits in the block until the register frees.
// Writes to a slot at or beyond ENTRIES are dropped but still answered.
// Reset is synchronous and active high; it clears every entry to inactive at
// once through per-entry valid flags, so no clearing pass is needed.
`default_nettype none

module next_alarm_selector_top #(
   parameter int ENTRIES = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  nas_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output nas_pkg::rsp_type rsp_data
);
   import nas_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Controller.
   state_type state_ff, state_in;
   logic      load_rsp;
   logic      req_fire;

   // Table memory and per-entry valid flags.
   logic [23:0]        mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [8:0]         idx_ext;

   // Scan address and pipeline.
   logic [AW-1:0] rd_addr_ff;
   logic          rd_last;
   logic [23:0]   rdata_ff;
   logic          ent_valid_ff;
   logic          p1_vld_ff;
   logic          p2_vld_ff;
   logic          elig;
   logic [13:0]   when_val;
   logic [13:0]   when_ff;
   logic          elig_ff;
   logic [7:0]    hour_ff;
   logic [7:0]    minute_ff;

   // Query state and running best.
   logic [10:0] now_ff;
   logic [15:0] distance;
   logic        better;
   logic [15:0] best_ff;
   logic [7:0]  best_hour_ff;
   logic [7:0]  best_minute_ff;
   logic        have_ff;

   // Response register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state and response load.
   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.action == ACTION_QUERY) ? ST_SCAN : ST_HOLD;
            end
         end
         ST_SCAN: begin
            if (rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Table write decode; slots beyond the table are dropped.
   assign idx_ext = 9'(req_data.entry_index);
   assign wr_en   = req_fire && (req_data.action == ACTION_WRITE) &&
                    (idx_ext < 9'(ENTRIES));
   assign wr_addr = AW'(req_data.entry_index);

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_data.entry_mode, req_data.entry_hour_bcd,
                          req_data.entry_minute_bcd};
      end
      rdata_ff <= mem[rd_addr_ff];
   end

   // Valid flags; an entry never written reads as inactive.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Scan address counter.
   assign rd_last = (rd_addr_ff == AW'(ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_addr_ff <= '0;
      end else if (state_ff == ST_SCAN && !rd_last) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
      end
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= (state_ff == ST_SCAN);
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      ent_valid_ff <= valid_ff[rd_addr_ff];
   end

   // Stage one: qualify the entry and turn its time into minutes of the day.
   assign elig = ent_valid_ff && (rdata_ff[23:16] == MODE_ACTIVE) &&
                 (rdata_ff[15:8] != UNSET_BYTE) && (rdata_ff[7:0] != UNSET_BYTE);
   assign when_val = 14'(bcd_value(rdata_ff[15:8])) * HOUR_MINUTES +
                     14'(bcd_value(rdata_ff[7:0]));

   always_ff @(posedge clock) begin
      elig_ff   <= elig;
      when_ff   <= when_val;
      hour_ff   <= rdata_ff[15:8];
      minute_ff <= rdata_ff[7:0];
   end

   // Stage two: distance ahead of now, wrapping to the next day.
   always_comb begin
      if (when_ff > 14'(now_ff)) begin
         distance = 16'(when_ff) - 16'(now_ff);
      end else begin
         distance = 16'(when_ff) + DAY_MINUTES - 16'(now_ff);
      end
   end

   // Strictly smaller wins, so the first entry keeps a tie.
   assign better = p2_vld_ff && elig_ff && (distance != 16'd0) && (distance < best_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff         <= req_data.now_minutes;
         best_ff        <= DIST_START;
         best_hour_ff   <= UNSET_BYTE;
         best_minute_ff <= UNSET_BYTE;
      end else if (better) begin
         best_ff        <= distance;
         best_hour_ff   <= hour_ff;
         best_minute_ff <= minute_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (req_fire) begin
         have_ff <= 1'b0;
      end else if (better) begin
         have_ff <= 1'b1;
      end
   end

   // Response contents, saturating the distance.
   always_comb begin
      rsp_next.found            = have_ff;
      rsp_next.alarm_hour_bcd   = best_hour_ff;
      rsp_next.alarm_minute_bcd = best_minute_ff;
      if (!have_ff) begin
         rsp_next.minutes_until = '0;
      end else if (best_ff > 16'(UNTIL_MAX)) begin
         rsp_next.minutes_until = UNTIL_MAX;
      end else begin
         rsp_next.minutes_until = best_ff[13:0];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

`ifndef SYNTHESIS
   // A response appears only after the block has finished its work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("response raised outside the hold state");

   // The compare pipeline only carries entries during a scan.
   assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("pipeline busy outside a scan");

   // A found alarm always has a usable distance.
   assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (best_ff != 16'd0 && best_ff != DIST_START))
      else $error("found alarm with an impossible distance");

   // A table write goes straight to its response.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.action == ACTION_WRITE) |=> (state_ff == ST_HOLD))
      else $error("write did not go to the hold state");
`endif

endmodule

`default_nettype wire
